// File: rtl/core/eeprom_update_sequencer_defines.svh
// assertion macros shared by the eeprom update sequencer rtl
// expects a clock named clk and an active-high reset named rst in the using module
`ifndef EEPROM_UPDATE_SEQUENCER_DEFINES_SVH
`define EEPROM_UPDATE_SEQUENCER_DEFINES_SVH

// same-cycle implication
`define EUS_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define EUS_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: rtl/core/eus_pkg.sv
// types and constants of the eeprom update sequencer
// no dependencies; used by the channel interfaces and the top level
package eus_pkg;

  localparam int REQ_W  = 3;
  localparam int ADDR_W = 10;
  localparam int LEN_W  = 5;
  localparam int IDX_W  = 4;
  localparam int BYTE_W = 8;
  localparam int TMO_W  = 8;

  localparam logic [TMO_W-1:0]  TIMEOUT_RESET = 8'd200;
  localparam logic [BYTE_W-1:0] ERASED        = 8'hFF;

  typedef enum logic [REQ_W-1:0] {
    REQ_START_READ   = 3'd0,
    REQ_START_UPDATE = 3'd1,
    REQ_LOAD_WRITE   = 3'd2,
    REQ_STEP         = 3'd3,
    REQ_TICK         = 3'd4,
    REQ_READ_RESULT  = 3'd5
  } req_code_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_READ    = 2'd1,
    PH_COMPARE = 2'd2,
    PH_WRITE   = 2'd3
  } phase_t;

endpackage

// File: rtl/core/eus_channels.sv
// valid/ready channel interfaces of the eeprom update sequencer
// depends on eus_pkg for field widths
interface eus_req_if;
  logic                        valid;
  logic                        ready;
  logic [eus_pkg::REQ_W-1:0]   req_type;
  logic [eus_pkg::ADDR_W-1:0]  address;
  logic [eus_pkg::LEN_W-1:0]   length;
  logic [eus_pkg::IDX_W-1:0]   index;
  logic [eus_pkg::BYTE_W-1:0]  data_in;
  logic                        array_busy;

  modport source(output valid, req_type, address, length, index, data_in, array_busy,
                 input ready);
  modport sink(input valid, req_type, address, length, index, data_in, array_busy,
               output ready);
endinterface

interface eus_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        busy_res;
  logic                        rejected;
  logic [eus_pkg::BYTE_W-1:0]  data_out;
  logic                        wrote;
  logic                        aborted;

  modport source(output valid, busy_res, rejected, data_out, wrote, aborted, input ready);
  modport sink(input valid, busy_res, rejected, data_out, wrote, aborted, output ready);
endinterface

interface eus_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [eus_pkg::TMO_W-1:0]   data;

  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

// File: rtl/core/eeprom_update_sequencer.sv
// eeprom update sequencer: read and read-compare-write over a byte cell array
// an accepted item passes through the input register and then the result register
// throughput: one item per cycle while the result side takes results, set by the step logic and the
//   prefetched cell array read port
// reset: control state clears at once; then a clearing pass over every cell
//   erases the cell array and the read buffer, during which no item is accepted
`include "eeprom_update_sequencer_defines.svh"

module eeprom_update_sequencer #(
  parameter int ARRAY_DEPTH  = 1024,
  parameter int BUFFER_BYTES = 16
) (
  input  logic       clk,
  input  logic       rst,
  eus_req_if.sink    req,
  eus_rsp_if.source  rsp,
  eus_cfg_if.sink    cfg
);
  import eus_pkg::*;

  localparam int AW = $clog2(ARRAY_DEPTH);
  localparam int BW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
  localparam int PW = $clog2(BUFFER_BYTES + 1);
  localparam int CW = $clog2((1 << ADDR_W) + BUFFER_BYTES);
  localparam logic [31:0] LIMIT   = 32'(ARRAY_DEPTH - 1);
  localparam logic [31:0] DEPTH32 = 32'(ARRAY_DEPTH);
  localparam logic [31:0] BB32    = 32'(BUFFER_BYTES);

  // clearing pass after reset
  logic          clearing;
  logic [AW-1:0] clr_idx;

  // configuration
  logic [TMO_W-1:0] timeout_ms;

  // input register
  logic              in_valid;
  logic [REQ_W-1:0]  in_req;
  logic [ADDR_W-1:0] in_addr;
  logic [LEN_W-1:0]  in_len;
  logic [IDX_W-1:0]  in_idx;
  logic [BYTE_W-1:0] in_data;
  logic              in_abusy;
  logic [BYTE_W-1:0] rb_idx_q;   // read buffer byte at the item's index, fetched at accept

  // operation state
  phase_t           phase, phase_next;
  logic [PW-1:0]    position, position_next;
  logic [CW-1:0]    cursor, cursor_next;
  logic [PW-1:0]    op_length, op_length_next;
  logic             read_only, read_only_next;
  logic [TMO_W-1:0] deadline, deadline_next;

  // storage
  logic [BYTE_W-1:0] cells [ARRAY_DEPTH];
  logic [BYTE_W-1:0] rbuf [BUFFER_BYTES];
  logic [BYTE_W-1:0] wbuf [BUFFER_BYTES];
  logic [BYTE_W-1:0] mem_rdata;   // cells[cursor], kept up to date every cycle
  logic              cell_ok;     // cursor lies inside the array
  logic [BYTE_W-1:0] rb_pos_q;    // rbuf[position]
  logic [BYTE_W-1:0] wb_pos_q;    // wbuf[position]

  // result register
  logic              res_valid;
  logic              res_busy;
  logic              res_rejected;
  logic [BYTE_W-1:0] res_data;
  logic              res_wrote;
  logic              res_aborted;

  // combinational control
  logic              acc;
  logic              proc;
  req_code_t         code;
  logic              is_start;
  logic [ADDR_W:0]   start_end;
  logic              start_bad;
  logic              step_go;
  logic              step_abort;
  logic              step_run;
  logic              pos_lt;
  logic [BYTE_W-1:0] cell_byte;
  logic              rb_we;
  logic [BW-1:0]     rb_wa;
  logic              wb_we;
  logic [BW-1:0]     wb_wa;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [AW-1:0]     mem_ra;
  logic              rd_ok;
  logic [BW-1:0]     pos_ra;
  logic [BW-1:0]     idx_ra;
  logic              clr_in_buf;

  logic              rejected_d;
  logic [BYTE_W-1:0] data_d;
  logic              wrote_d;
  logic              aborted_d;
  logic              busy_d;

  // an item in the input register is worked off when the result register can take it
  assign proc = in_valid && (!res_valid || rsp.ready);
  assign acc  = req.valid && req.ready;
  assign req.ready = !clearing && (!in_valid || proc);
  assign cfg.ready = 1'b1;

  assign code      = req_code_t'(in_req);
  assign is_start  = (code == REQ_START_READ) || (code == REQ_START_UPDATE);
  assign start_end = (ADDR_W + 1)'(in_addr) + (ADDR_W + 1)'(in_len);
  // range check: start plus length must stay below the index of the last cell, nor may the length overflow the buffer
  assign start_bad = (32'(start_end) >= LIMIT) || (32'(in_len) > BB32);

  // a step does nothing while the array programs or while no operation runs
  assign step_go    = proc && (code == REQ_STEP) && !in_abusy && (phase != PH_IDLE);
  assign step_abort = step_go && (deadline == '0);
  assign step_run   = step_go && (deadline != '0);
  assign pos_lt     = position < op_length;
  assign cell_byte  = cell_ok ? mem_rdata : ERASED;

  // write addresses
  assign rb_wa  = BW'(position);
  assign wb_wa  = BW'(in_idx);
  assign mem_wa = AW'(cursor);

  // read addresses follow the state that the next item will see
  assign rd_ok  = 32'(cursor_next) < DEPTH32;
  assign mem_ra = rd_ok ? AW'(cursor_next) : '0;
  assign pos_ra = (32'(position_next) < BB32) ? BW'(position_next) : '0;
  assign idx_ra = (32'(req.index) < BB32) ? BW'(req.index) : '0;
  assign clr_in_buf = 32'(clr_idx) < BB32;

  // next state of the sequencer
  always_comb begin : next_state
    phase_next     = phase;
    position_next  = position;
    cursor_next    = cursor;
    op_length_next = op_length;
    read_only_next = read_only;
    deadline_next  = deadline;
    rb_we  = 1'b0;
    wb_we  = 1'b0;
    mem_we = 1'b0;
    if (proc) begin
      case (code)
        REQ_START_READ, REQ_START_UPDATE: begin
          // a good start replaces whatever runs
          if (!start_bad) begin
            cursor_next    = CW'(in_addr);
            op_length_next = PW'(in_len);
            read_only_next = (code == REQ_START_READ);
            position_next  = '0;
            phase_next     = PH_READ;
            deadline_next  = timeout_ms;
          end
        end
        REQ_LOAD_WRITE: begin
          if (32'(in_idx) < BB32) begin
            wb_we = 1'b1;
          end
        end
        REQ_STEP: begin
          if (step_abort) begin
            phase_next    = PH_IDLE;
            position_next = '0;
            cursor_next   = '0;
          end else if (step_run) begin
            case (phase)
              PH_READ: begin
                if (pos_lt) begin
                  rb_we         = 1'b1;
                  position_next = position + PW'(1);
                  cursor_next   = cursor + CW'(1);
                end else begin
                  position_next = '0;
                  if (read_only) begin
                    cursor_next = '0;
                    phase_next  = PH_IDLE;
                  end else begin
                    // rewind for the compare pass
                    cursor_next = cursor - CW'(op_length);
                    phase_next  = PH_COMPARE;
                  end
                end
              end
              PH_COMPARE: begin
                if (pos_lt) begin
                  if (rb_pos_q == wb_pos_q) begin
                    position_next = position + PW'(1);
                    cursor_next   = cursor + CW'(1);
                  end else begin
                    phase_next = PH_WRITE;
                  end
                end else begin
                  phase_next    = PH_IDLE;
                  position_next = '0;
                end
              end
              PH_WRITE: begin
                // program the differing byte, then resume comparing
                mem_we        = 32'(cursor) < DEPTH32;
                cursor_next   = cursor + CW'(1);
                position_next = position + PW'(1);
                phase_next    = PH_COMPARE;
              end
              default: ;
            endcase
          end
        end
        REQ_TICK: begin
          if (deadline != '0) begin
            deadline_next = deadline - TMO_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // result fields of the item being worked off
  always_comb begin : result_fields
    rejected_d = proc && is_start && start_bad;
    data_d     = (proc && (code == REQ_READ_RESULT) && (32'(in_idx) < BB32)) ? rb_idx_q : '0;
    wrote_d    = step_run && (phase == PH_WRITE);
    aborted_d  = step_abort;
    busy_d     = phase_next != PH_IDLE;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clr_idx    <= '0;
      timeout_ms <= TIMEOUT_RESET;
      in_valid   <= 1'b0;
      res_valid  <= 1'b0;
      phase      <= PH_IDLE;
      position   <= '0;
      cursor     <= '0;
      op_length  <= '0;
      read_only  <= 1'b0;
      deadline   <= '0;
    end else begin
      if (clearing) begin
        clr_idx <= clr_idx + AW'(1);
        if (clr_idx == AW'(ARRAY_DEPTH - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (cfg.valid) begin
        timeout_ms <= cfg.data;
      end
      if (acc) begin
        in_valid <= 1'b1;
      end else if (proc) begin
        in_valid <= 1'b0;
      end
      if (proc) begin
        res_valid <= 1'b1;
      end else if (rsp.ready) begin
        res_valid <= 1'b0;
      end
      phase     <= phase_next;
      position  <= position_next;
      cursor    <= cursor_next;
      op_length <= op_length_next;
      read_only <= read_only_next;
      deadline  <= deadline_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (acc) begin
      in_req   <= req.req_type;
      in_addr  <= req.address;
      in_len   <= req.length;
      in_idx   <= req.index;
      in_data  <= req.data_in;
      in_abusy <= req.array_busy;
    end
    if (proc) begin
      res_busy     <= busy_d;
      res_rejected <= rejected_d;
      res_data     <= data_d;
      res_wrote    <= wrote_d;
      res_aborted  <= aborted_d;
    end
    cell_ok <= rd_ok;
  end

  // cell array: one write port, one read port at the next cursor
  always_ff @(posedge clk) begin
    if (clearing) begin
      cells[clr_idx] <= ERASED;
    end else if (mem_we) begin
      cells[mem_wa] <= wb_pos_q;
    end
    mem_rdata <= cells[mem_ra];
  end

  // read buffer: filled by read steps, read at the next position and at an item's index
  always_ff @(posedge clk) begin
    if (clearing && clr_in_buf) begin
      rbuf[BW'(clr_idx)] <= ERASED;
    end else if (rb_we) begin
      rbuf[rb_wa] <= cell_byte;
    end
    rb_pos_q <= (rb_we && (rb_wa == pos_ra)) ? cell_byte : rbuf[pos_ra];
    if (acc) begin
      rb_idx_q <= (rb_we && (rb_wa == idx_ra)) ? cell_byte : rbuf[idx_ra];
    end
  end

  // write buffer: loaded by items, read at the next position
  always_ff @(posedge clk) begin
    if (wb_we) begin
      wbuf[wb_wa] <= in_data;
    end
    wb_pos_q <= (wb_we && (wb_wa == pos_ra)) ? in_data : wbuf[pos_ra];
  end

  assign rsp.valid    = res_valid;
  assign rsp.busy_res = res_busy;
  assign rsp.rejected = res_rejected;
  assign rsp.data_out = res_data;
  assign rsp.wrote    = res_wrote;
  assign rsp.aborted  = res_aborted;

  // checks
  `EUS_ASSERT_IMP(a_no_accept_clearing, clearing, !req.ready, "item taken during clearing pass")
  `EUS_ASSERT_NXT(a_abort_idle, step_abort, (phase == PH_IDLE) && (position == '0), "abort did not idle")
  `EUS_ASSERT_IMP(a_prog_in_write, mem_we, (phase == PH_WRITE) && !clearing, "program outside write")
  `EUS_ASSERT_IMP(a_pos_bound, phase != PH_IDLE, position <= op_length, "position past length")

endmodule

// File: dv/tb_top.sv
// self-checking testbench of the eeprom update sequencer: directed table, then random phases
// depends on eus_pkg and the channel interfaces in rtl/core, and on the sequencer top level
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import eus_pkg::*;

  localparam int ARRAY_DEPTH  = 1024;
  localparam int BUFFER_BYTES = 16;

  // request codes with no function in the block
  localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;

  // random part: six phases with their own timeout and idling mix
  localparam int PHASES           = 6;
  localparam int PHASE_ITEMS      = 250;
  localparam int RANDOM_TMO_PHASE = 3;
  localparam int SEND_IDLE [PHASES]  = '{0, 69, 0, 38, 0, 38};
  localparam int RECV_STALL [PHASES] = '{0, 0, 69, 38, 0, 38};
  localparam logic [TMO_W-1:0] TIMEOUT_PLAN [PHASES] =
    '{8'd255, 8'd1, 8'd6, 8'd128, 8'd3, 8'd200};

  typedef struct packed {
    logic [REQ_W-1:0]  req;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    logic [IDX_W-1:0]  idx;
    logic [BYTE_W-1:0] din;
    logic              abusy;
  } req_item_t;

  typedef struct packed {
    logic              busy;
    logic              rejected;
    logic [BYTE_W-1:0] data_out;
    logic              wrote;
    logic              aborted;
  } rsp_item_t;

  // one row of the directed plan: either a timeout write or a request repeated reps times
  typedef struct packed {
    logic              is_cfg;
    logic [TMO_W-1:0]  cfg_val;
    req_item_t         item;
    logic [7:0]        reps;
    logic              typed;
    rsp_item_t         want;
  } plan_row_t;

  // expectations that can be read off directly
  localparam rsp_item_t NONE      = '0;
  localparam rsp_item_t QUIET     = '0;
  localparam rsp_item_t ACTIVE    = '{1'b1, 1'b0, 8'h00, 1'b0, 1'b0};
  localparam rsp_item_t REJECT    = '{1'b0, 1'b1, 8'h00, 1'b0, 1'b0};
  localparam rsp_item_t ABORT     = '{1'b0, 1'b0, 8'h00, 1'b0, 1'b1};
  localparam rsp_item_t ERASED_RD = '{1'b0, 1'b0, ERASED, 1'b0, 1'b0};

  localparam int PLAN_ROWS = 29;
  localparam plan_row_t DIRECTED_PLAN [PLAN_ROWS] = '{
    // read buffer comes out of reset erased
    '{1'b0, 8'd0, '{REQ_READ_RESULT, 10'd0, 5'd0, 4'd0, 8'd0, 1'b0}, 8'd1, 1'b1, ERASED_RD},
    '{1'b0, 8'd0, '{REQ_READ_RESULT, 10'd0, 5'd0, 4'd15, 8'd0, 1'b0}, 8'd1, 1'b1, ERASED_RD},
    // range checks: end touching the last cell, length over the buffer, all ones
    '{1'b0, 8'd0, '{REQ_START_READ, 10'd1007, 5'd16, 4'd0, 8'd0, 1'b0}, 8'd1, 1'b1, REJECT},
    '{1'b0, 8'd0, '{REQ_START_UPDATE, 10'd0, 5'd17, 4'd0, 8'd0, 1'b0}, 8'd1, 1'b1, REJECT},
    '{1'b0, 8'd0, '{REQ_START_UPDATE, 10'd1023, 5'd31, 4'd15, 8'd255, 1'b1}, 8'd1, 1'b1,
      REJECT},
    // largest legal read, one step held off by a busy array, one step taken
    '{1'b0, 8'd0, '{REQ_START_READ, 10'd1006, 5'd16, 4'd0, 8'd0, 1'b0}, 8'd1, 1'b1, ACTIVE},
    '{1'b0, 8'd0, '{REQ_STEP, 10'd0, 5'd0, 4'd0, 8'd0, 1'b1}, 8'd1, 1'b1, ACTIVE},
    '{1'b0, 8'd0, '{REQ_STEP, 10'd0, 5'd0, 4'd0, 8'd0, 1'b0}, 8'd1, 1'b0, NONE},
    // write bytes loaded while the read still runs
    '{1'b0, 8'd0, '{REQ_LOAD_WRITE, 10'd0, 5'd0, 4'd0, 8'h00, 1'b0}, 8'd1, 1'b0, NONE},
    '{1'b0, 8'd0, '{REQ_LOAD_WRITE, 10'd0, 5'd0, 4'd1, 8'hFF, 1'b0}, 8'd1, 1'b0, NONE},
    '{1'b0, 8'd0, '{REQ_LOAD_WRITE, 10'd0, 5'd0, 4'd15, 8'hA5, 1'b0}, 8'd1, 1'b0, NONE},
    // update replaces the read: one byte differs, one matches
    '{1'b0, 8'd0, '{REQ_START_UPDATE, 10'd0, 5'd2, 4'd0, 8'd0, 1'b0}, 8'd1, 1'b1, ACTIVE},
    '{1'b0, 8'd0, '{REQ_STEP, 10'd0, 5'd0, 4'd0, 8'd0, 1'b0}, 8'd7, 1'b0, NONE},
    // read back the programmed cell
    '{1'b0, 8'd0, '{REQ_START_READ, 10'd0, 5'd1, 4'd0, 8'd0, 1'b0}, 8'd1, 1'b0, NONE},
    '{1'b0, 8'd0, '{REQ_STEP, 10'd0, 5'd0, 4'd0, 8'd0, 1'b0}, 8'd2, 1'b0, NONE},
    '{1'b0, 8'd0, '{REQ_READ_RESULT, 10'd0, 5'd0, 4'd0, 8'd0, 1'b0}, 8'd1, 1'b0, NONE},
    // zero length ends on the first step
    '{1'b0, 8'd0, '{REQ_START_READ, 10'd5, 5'd0, 4'd0, 8'd0, 1'b0}, 8'd1, 1'b0, NONE},
    '{1'b0, 8'd0, '{REQ_STEP, 10'd0, 5'd0, 4'd0, 8'd0, 1'b0}, 8'd1, 1'b0, NONE},
    // unused request codes
    '{1'b0, 8'd0, '{REQ_SPARE_LO, 10'd1023, 5'd31, 4'd15, 8'd255, 1'b1}, 8'd1, 1'b0, NONE},
    '{1'b0, 8'd0, '{REQ_SPARE_HI, 10'd0, 5'd0, 4'd0, 8'd0, 1'b0}, 8'd1, 1'b0, NONE},
    // deadline runs out after one tick, second tick holds it at zero
    '{1'b1, 8'd1, '{REQ_SPARE_HI, 10'd0, 5'd0, 4'd0, 8'd0, 1'b0}, 8'd0, 1'b0, NONE},
    '{1'b0, 8'd0, '{REQ_START_READ, 10'd1, 5'd4, 4'd0, 8'd0, 1'b0}, 8'd1, 1'b1, ACTIVE},
    '{1'b0, 8'd0, '{REQ_TICK, 10'd0, 5'd0, 4'd0, 8'd0, 1'b0}, 8'd2, 1'b0, NONE},
    '{1'b0, 8'd0, '{REQ_STEP, 10'd0, 5'd0, 4'd0, 8'd0, 1'b0}, 8'd1, 1'b1, ABORT},
    // zero timeout, with a start replacing a running update
    '{1'b1, 8'd0, '{REQ_SPARE_HI, 10'd0, 5'd0, 4'd0, 8'd0, 1'b0}, 8'd0, 1'b0, NONE},
    '{1'b0, 8'd0, '{REQ_START_UPDATE, 10'd0, 5'd2, 4'd0, 8'd0, 1'b0}, 8'd1, 1'b1, ACTIVE},
    '{1'b0, 8'd0, '{REQ_START_UPDATE, 10'd10, 5'd2, 4'd0, 8'd0, 1'b0}, 8'd1, 1'b1, ACTIVE},
    '{1'b0, 8'd0, '{REQ_STEP, 10'd0, 5'd0, 4'd0, 8'd0, 1'b0}, 8'd1, 1'b1, ABORT},
    '{1'b0, 8'd0, '{REQ_STEP, 10'd0, 5'd0, 4'd0, 8'd0, 1'b0}, 8'd1, 1'b1, QUIET}
  };

  logic clk;
  logic rst;

  eus_req_if req_ch ();
  eus_rsp_if rsp_ch ();
  eus_cfg_if cfg_ch ();

  eeprom_update_sequencer #(
    .ARRAY_DEPTH (ARRAY_DEPTH),
    .BUFFER_BYTES(BUFFER_BYTES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  // predicted copy of the sequencer state
  logic [TMO_W-1:0]  timeout_val;
  phase_t            seq_phase;
  logic [LEN_W-1:0]  seq_pos;
  logic [ADDR_W-1:0] seq_cursor;
  logic [LEN_W-1:0]  seq_len;
  logic              seq_read_only;
  logic [TMO_W-1:0]  seq_deadline;
  logic [BYTE_W-1:0] rd_buf [BUFFER_BYTES];
  logic [BYTE_W-1:0] wr_buf [BUFFER_BYTES];
  logic [BYTE_W-1:0] cells  [ARRAY_DEPTH];

  // outcomes predicted for accepted requests, oldest first
  rsp_item_t outcomes_due [$];

  int send_idle_pct;
  int recv_stall_pct;
  int sent_count;
  int checked_count;
  int fail_count;
  int program_count;
  int abort_count;
  int reject_count;
  int tmo_settings;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  // advance the predicted state by one accepted request and return its outcome
  function automatic rsp_item_t predict_outcome(req_item_t it);
    rsp_item_t o;
    o = '0;
    case (it.req)
      REQ_START_READ, REQ_START_UPDATE: begin
        if (int'(it.addr) + int'(it.len) >= ARRAY_DEPTH - 1 || int'(it.len) > BUFFER_BYTES) begin
          o.rejected = 1'b1;
        end else begin
          seq_cursor    = it.addr;
          seq_len       = it.len;
          seq_read_only = (it.req == REQ_START_READ);
          seq_pos       = '0;
          seq_phase     = PH_READ;
          seq_deadline  = timeout_val;
        end
      end
      REQ_LOAD_WRITE: begin
        wr_buf[it.idx] = it.din;
      end
      REQ_STEP: begin
        if (!it.abusy && seq_phase != PH_IDLE) begin
          if (seq_deadline == '0) begin
            // expired deadline wins over any progress
            seq_phase  = PH_IDLE;
            seq_pos    = '0;
            seq_cursor = '0;
            o.aborted  = 1'b1;
          end else begin
            case (seq_phase)
              PH_READ: begin
                if (seq_pos < seq_len) begin
                  rd_buf[seq_pos[IDX_W-1:0]] = cells[seq_cursor];
                  seq_pos++;
                  seq_cursor++;
                end else begin
                  seq_pos = '0;
                  if (seq_read_only) begin
                    seq_cursor = '0;
                    seq_phase  = PH_IDLE;
                  end else begin
                    seq_cursor = seq_cursor - seq_len;
                    seq_phase  = PH_COMPARE;
                  end
                end
              end
              PH_COMPARE: begin
                if (seq_pos < seq_len) begin
                  if (rd_buf[seq_pos[IDX_W-1:0]] == wr_buf[seq_pos[IDX_W-1:0]]) begin
                    seq_pos++;
                    seq_cursor++;
                  end else begin
                    seq_phase = PH_WRITE;
                  end
                end else begin
                  seq_phase = PH_IDLE;
                  seq_pos   = '0;
                end
              end
              default: begin
                cells[seq_cursor] = wr_buf[seq_pos[IDX_W-1:0]];
                seq_cursor++;
                seq_pos++;
                seq_phase = PH_COMPARE;
                o.wrote   = 1'b1;
              end
            endcase
          end
        end
      end
      REQ_TICK: begin
        if (seq_deadline != '0) seq_deadline--;
      end
      REQ_READ_RESULT: begin
        o.data_out = rd_buf[it.idx];
      end
      default: ;
    endcase
    o.busy = (seq_phase != PH_IDLE);
    return o;
  endfunction

  // byte values biased so that compares often match the cells
  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(3))
      0: return 8'h00;
      1: return ERASED;
      2: return 8'h5A;
      default: return BYTE_W'($urandom);
    endcase
  endfunction

  // all driving tasks start and end just after a falling edge
  task automatic push_request(req_item_t it, logic typed = 1'b0, rsp_item_t want = '0);
    rsp_item_t outcome;
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= it.req;
    req_ch.address    <= it.addr;
    req_ch.length     <= it.len;
    req_ch.index      <= it.idx;
    req_ch.data_in    <= it.din;
    req_ch.array_busy <= it.abusy;
    do @(posedge clk); while (!req_ch.ready);
    outcome = predict_outcome(it);
    outcomes_due.push_back(typed ? want : outcome);
    sent_count++;
    @(negedge clk);
  endtask

  // hold the request side until every predicted outcome has been seen
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(negedge clk);
    while (outcomes_due.size() != 0) @(negedge clk);
  endtask

  task automatic write_timeout(logic [TMO_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    timeout_val = value;
    tmo_settings++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // mostly complete operations with random content, the rest loose noise
  task automatic run_random_phase(int n_items);
    req_item_t it;
    int        stop_at;
    int        guard;
    int        pick;
    stop_at = sent_count + n_items;
    while (sent_count < stop_at) begin
      if ($urandom_range(99) < 80) begin
        repeat ($urandom_range(0, 3)) begin
          it      = '0;
          it.req  = REQ_LOAD_WRITE;
          it.idx  = IDX_W'($urandom);
          it.din  = pick_byte();
          push_request(it);
        end
        it       = req_item_t'($urandom);
        it.req   = ($urandom_range(9) < 6) ? REQ_START_UPDATE : REQ_START_READ;
        it.len   = ($urandom_range(9) == 0) ? LEN_W'($urandom_range(17, 31))
                                            : LEN_W'($urandom_range(0, 16));
        // a small window of cells keeps previously programmed bytes in play
        if ($urandom_range(3) != 0) it.addr = ADDR_W'($urandom_range(0, 40));
        else if ($urandom_range(9) == 0) it.addr = ADDR_W'($urandom_range(1000, 1023));
        else it.addr = ADDR_W'($urandom_range(0, 1006));
        push_request(it);
        guard = 0;
        while (seq_phase != PH_IDLE && guard < 120) begin
          pick     = $urandom_range(99);
          it       = req_item_t'($urandom);
          it.abusy = ($urandom_range(6) == 0);
          if (pick < 8) it.req = REQ_TICK;
          else if (pick < 12) it.req = REQ_READ_RESULT;
          else if (pick < 14) it.req = REQ_LOAD_WRITE;
          else it.req = REQ_STEP;
          push_request(it);
          guard++;
        end
        repeat ($urandom_range(0, 3)) begin
          it     = req_item_t'($urandom);
          it.req = REQ_READ_RESULT;
          push_request(it);
        end
        // occasional full pause on the request side
        if ($urandom_range(99) == 0) wait_drained();
      end else begin
        it     = req_item_t'($urandom);
        it.req = REQ_W'($urandom_range(0, 7));
        push_request(it);
      end
    end
  endtask

  // result side: ready is drawn anew at the falling edge with the stall rate of the phase
  always @(negedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // compare every accepted result with the oldest prediction
  always @(posedge clk) begin : check_results
    rsp_item_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (rsp_ch.wrote === 1'b1) program_count++;
      if (rsp_ch.aborted === 1'b1) abort_count++;
      if (rsp_ch.rejected === 1'b1) reject_count++;
      if (outcomes_due.size() == 0) begin
        $error("result item with no request outstanding");
        fail_count++;
      end else begin
        want = outcomes_due.pop_front();
        checked_count++;
        if (rsp_ch.busy_res !== want.busy) begin
          $error("busy_res: expected %0d, got %0d", want.busy, rsp_ch.busy_res);
          fail_count++;
        end
        if (rsp_ch.rejected !== want.rejected) begin
          $error("rejected: expected %0d, got %0d", want.rejected, rsp_ch.rejected);
          fail_count++;
        end
        if (rsp_ch.data_out !== want.data_out) begin
          $error("data_out: expected 0x%02h, got 0x%02h", want.data_out, rsp_ch.data_out);
          fail_count++;
        end
        if (rsp_ch.wrote !== want.wrote) begin
          $error("wrote: expected %0d, got %0d", want.wrote, rsp_ch.wrote);
          fail_count++;
        end
        if (rsp_ch.aborted !== want.aborted) begin
          $error("aborted: expected %0d, got %0d", want.aborted, rsp_ch.aborted);
          fail_count++;
        end
      end
    end
  end

  initial begin
    // every block input known from time zero
    rst               = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.req_type   = '0;
    req_ch.address    = '0;
    req_ch.length     = '0;
    req_ch.index      = '0;
    req_ch.data_in    = '0;
    req_ch.array_busy = 1'b0;
    rsp_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.data       = '0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    sent_count        = 0;
    checked_count     = 0;
    fail_count        = 0;
    program_count     = 0;
    abort_count       = 0;
    reject_count      = 0;
    tmo_settings      = 0;

    // predicted state after reset
    timeout_val   = TIMEOUT_RESET;
    seq_phase     = PH_IDLE;
    seq_pos       = '0;
    seq_cursor    = '0;
    seq_len       = '0;
    seq_read_only = 1'b0;
    seq_deadline  = '0;
    for (int i = 0; i < BUFFER_BYTES; i++) begin
      rd_buf[i] = ERASED;
      wr_buf[i] = '0;
    end
    for (int i = 0; i < ARRAY_DEPTH; i++) cells[i] = ERASED;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table; the clearing pass after reset just holds off the first accept
    foreach (DIRECTED_PLAN[r]) begin
      if (DIRECTED_PLAN[r].is_cfg) begin
        wait_drained();
        repeat (4) @(negedge clk);
        write_timeout(DIRECTED_PLAN[r].cfg_val);
      end else begin
        repeat (DIRECTED_PLAN[r].reps)
          push_request(DIRECTED_PLAN[r].item, DIRECTED_PLAN[r].typed, DIRECTED_PLAN[r].want);
      end
    end

    // random phases, each with a fresh timeout written while no request is outstanding
    for (int p = 0; p < PHASES; p++) begin : random_phases
      req_item_t fill;
      logic [TMO_W-1:0] tmo;
      wait_drained();
      repeat (4) @(negedge clk);
      tmo = (p == RANDOM_TMO_PHASE) ? TMO_W'($urandom_range(2, 254)) : TIMEOUT_PLAN[p];
      write_timeout(tmo);
      send_idle_pct  = SEND_IDLE[p];
      recv_stall_pct = RECV_STALL[p];
      // whole write buffer defined before any random update compares against it
      if (p == 0) begin
        for (int i = 0; i < BUFFER_BYTES; i++) begin
          fill     = '0;
          fill.req = REQ_LOAD_WRITE;
          fill.idx = IDX_W'(i);
          fill.din = pick_byte();
          push_request(fill);
        end
      end
      run_random_phase(PHASE_ITEMS);
    end

    wait_drained();
    repeat (8) @(posedge clk);

    $display("ran %0d request items, %0d results checked, %0d timeout settings written",
             sent_count, checked_count, tmo_settings);
    $display("seen %0d bytes programmed, %0d deadline aborts, %0d rejected starts",
             program_count, abort_count, reject_count);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
